// ----- design/wsg_pkg.sv -----
package wsg_pkg;

  // Host transaction codes
  localparam logic [1:0] MODE_ADDR = 2'd0;
  localparam logic [1:0] MODE_WR   = 2'd1;
  localparam logic [1:0] MODE_RD   = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  // Divider operand selection
  localparam logic [1:0] DIV_PERIOD = 2'd0;
  localparam logic [1:0] DIV_STEPS  = 2'd1;
  localparam logic [1:0] DIV_LEN    = 2'd2;

  localparam int RAM_BYTES = 128;
  localparam int RAM_AW    = 7;
  localparam int DVD_W     = 25;  // dividend / quotient width
  localparam int DVS_W     = 23;  // divisor width
  localparam logic [4:0] DIV_ITER = 5'd25;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] bus_value;
    logic [4:0] tick_cycles;
  } in_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [15:0] sample;
  } out_t;

  typedef struct packed {
    logic       clr_step;
    logic       capture;
    logic       exec;
    logic       ch_init;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_step;
    logic       save_period;
    logic       keep_phase;
    logic       save_steps;
    logic       wrap_fetch;
    logic       nib_upd;
    logic       accumulate;
    logic       ch_next;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       div_done;
    logic       freq_zero;
    logic       step_needed;
    logic       ch_last;
    logic [1:0] mode;
  } stat_t;

endpackage

// ----- design/wsg_ctrl.sv -----
module wsg_ctrl
  import wsg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_TINIT = 4'd3;
  localparam logic [3:0] S_CHST  = 4'd4;
  localparam logic [3:0] S_DIV1  = 4'd5;
  localparam logic [3:0] S_P1    = 4'd6;
  localparam logic [3:0] S_P2    = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_P3    = 4'd9;
  localparam logic [3:0] S_DIV3  = 4'd10;
  localparam logic [3:0] S_P4    = 4'd11;
  localparam logic [3:0] S_P5    = 4'd12;
  localparam logic [3:0] S_ACC   = 4'd13;
  localparam logic [3:0] S_NEXT  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_done) begin
          cmd.clr_step = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.mode == MODE_TICK) begin
          state_nxt = S_TINIT;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_TINIT: begin
        cmd.ch_init = 1'b1;
        state_nxt   = S_CHST;
      end
      S_CHST: begin
        if (stat.freq_zero) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_PERIOD;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (stat.div_done) state_nxt = S_P1;
        else cmd.div_step = 1'b1;
      end
      S_P1: begin
        cmd.save_period = 1'b1;
        state_nxt       = S_P2;
      end
      S_P2: begin
        if (stat.step_needed) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_STEPS;
          state_nxt     = S_DIV2;
        end else begin
          cmd.keep_phase = 1'b1;
          state_nxt      = S_ACC;
        end
      end
      S_DIV2: begin
        if (stat.div_done) state_nxt = S_P3;
        else cmd.div_step = 1'b1;
      end
      S_P3: begin
        cmd.save_steps = 1'b1;
        cmd.div_start  = 1'b1;
        cmd.div_sel    = DIV_LEN;
        state_nxt      = S_DIV3;
      end
      S_DIV3: begin
        if (stat.div_done) state_nxt = S_P4;
        else cmd.div_step = 1'b1;
      end
      S_P4: begin
        cmd.wrap_fetch = 1'b1;
        state_nxt      = S_P5;
      end
      S_P5: begin
        cmd.nib_upd = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_nxt      = S_NEXT;
      end
      S_NEXT: begin
        if (stat.ch_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ch_next = 1'b1;
          state_nxt   = S_CHST;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/wsg_dp.sv -----
module wsg_dp
  import wsg_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output out_t  out_data
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [2:0] FIRST_WIN = 3'(8 - NUM_CHANNELS);
  localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);

  // Captured transaction
  in_t in_r;

  // Wave RAM and host registers
  logic [7:0]        ram [RAM_BYTES];
  logic [7:0]        ram_q_r;
  logic [RAM_AW:0]   clr_cnt_r;
  logic [RAM_AW-1:0] ptr_r;
  logic              ainc_r;
  logic [3:0]        act_r;

  // Channel state
  logic [17:0] freq_r  [NUM_CHANNELS];
  logic [5:0]  len_r   [NUM_CHANNELS];
  logic [7:0]  base_r  [NUM_CHANNELS];
  logic [3:0]  vol_r   [NUM_CHANNELS];
  logic [3:0]  nib_r   [NUM_CHANNELS];
  logic [4:0]  pos_r   [NUM_CHANNELS];
  logic [23:0] phase_r [NUM_CHANNELS];

  // Tick working registers
  logic [CW-1:0]      ch_r;
  logic [DVS_W-1:0]   period_r;
  logic [DVD_W-1:0]   psum_r;
  logic               nib_hi_r;
  logic signed [10:0] acc_r;

  // Shared restoring divider
  logic [DVD_W-1:0] q_r;
  logic [DVS_W:0]   rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [4:0]       div_cnt_r;
  logic [DVS_W:0]   trial;

  out_t out_r;

  // Host access decode
  logic [2:0]    wr_win;
  logic [2:0]    wr_off;
  logic [2:0]    wr_c3;
  logic [CW-1:0] wr_ch;
  logic          wr_chan;
  logic [5:0]    new_len;
  logic          host_wr;
  logic          host_rd;

  assign host_wr = cmd.exec && (in_r.mode == MODE_WR);
  assign host_rd = cmd.exec && (in_r.mode == MODE_RD);
  assign wr_win  = ptr_r[5:3];
  assign wr_off  = ptr_r[2:0];
  assign wr_c3   = wr_win - FIRST_WIN;
  assign wr_ch   = wr_c3[CW-1:0];
  assign wr_chan = host_wr && ptr_r[6] && (wr_win >= FIRST_WIN);
  assign new_len = 6'h20 - {1'b0, in_r.bus_value[4:2], 2'b00};

  // First channel of a tick
  logic [3:0]    st_win;
  logic [2:0]    st_c3;
  always_comb begin
    st_win = (act_r >= 4'd8) ? 4'd0 : 4'd8 - act_r;
    if (st_win < {1'b0, FIRST_WIN}) st_win = {1'b0, FIRST_WIN};
    st_c3 = st_win[2:0] - FIRST_WIN;
  end

  // Divider operand selection and step
  logic [DVD_W-1:0] dvd_sel;
  logic [DVS_W-1:0] dvs_sel;
  logic [7:0]       act15;
  assign act15 = {act_r, 4'b0000} - {4'b0000, act_r};
  always_comb begin
    case (cmd.div_sel)
      DIV_PERIOD: begin
        dvd_sel = {1'b0, act15, 16'h0000};
        dvs_sel = {5'b0, freq_r[ch_r]};
      end
      DIV_STEPS: begin
        dvd_sel = psum_r - DVD_W'(1);
        dvs_sel = period_r;
      end
      default: begin
        dvd_sel = q_r;
        dvs_sel = {17'b0, len_r[ch_r]};
      end
    endcase
  end
  assign trial = {rem_r[DVS_W-1:0], q_r[DVD_W-1]};

  // Position wrap and nibble address
  logic [5:0] r_len;
  logic [5:0] pos_sum;
  logic [4:0] pos_new;
  logic [7:0] fetch_a;
  always_comb begin
    r_len   = (len_r[ch_r] == 6'd0) ? 6'd1 : len_r[ch_r];
    pos_sum = {1'b0, pos_r[ch_r]} + rem_r[5:0];
    pos_new = (pos_sum >= r_len) ? 5'(pos_sum - r_len) : pos_sum[4:0];
    fetch_a = base_r[ch_r] + {3'b000, pos_new};
  end

  // Channel contribution
  logic signed [5:0]  nib_s;
  logic signed [10:0] prod;
  assign nib_s = $signed({2'b00, nib_r[ch_r]}) - 6'sd8;
  assign prod  = 11'(nib_s) * 11'($signed({1'b0, vol_r[ch_r]}));

  // Status to the sequencer
  assign stat.clear_done  = clr_cnt_r[RAM_AW];
  assign stat.div_done    = (div_cnt_r == 5'd0);
  assign stat.freq_zero   = (freq_r[ch_r] == 18'd0);
  assign stat.step_needed = (psum_r > {2'b00, period_r});
  assign stat.ch_last     = (ch_r == LAST_CH);
  assign stat.mode        = in_r.mode;

  assign out_data = out_r;

  // Wave RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) ram[clr_cnt_r[RAM_AW-1:0]] <= 8'h00;
    else if (host_wr) ram[ptr_r] <= in_r.bus_value;
    if (cmd.wrap_fetch) ram_q_r <= ram[fetch_a[7:1]];
    else if (host_rd) ram_q_r <= ram[ptr_r];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.out_load) begin
      out_r.read_data <= (in_r.mode == MODE_RD) ? ram_q_r : 8'h00;
      out_r.sample    <= (in_r.mode == MODE_TICK) ? {acc_r, 5'b00000} : 16'sd0;
    end
    if (cmd.save_period) begin
      period_r <= (q_r == '0) ? DVS_W'(1) : q_r[DVS_W-1:0];
      psum_r   <= {1'b0, phase_r[ch_r]} + DVD_W'(in_r.tick_cycles);
    end
    if (cmd.wrap_fetch) nib_hi_r <= fetch_a[0];
    if (cmd.div_start) begin
      q_r   <= dvd_sel;
      rem_r <= '0;
      dvs_r <= dvs_sel;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= trial - {1'b0, dvs_r};
        q_r   <= {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  // Control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      ptr_r     <= '0;
      ainc_r    <= 1'b1;
      act_r     <= 4'd8;
      ch_r      <= '0;
      acc_r     <= '0;
      div_cnt_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        freq_r[i]  <= '0;
        len_r[i]   <= 6'd16;
        base_r[i]  <= '0;
        vol_r[i]   <= '0;
        nib_r[i]   <= '0;
        pos_r[i]   <= '0;
        phase_r[i] <= '0;
      end
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      // address port
      if (cmd.exec && (in_r.mode == MODE_ADDR)) begin
        ptr_r  <= in_r.bus_value[RAM_AW-1:0];
        ainc_r <= in_r.bus_value[7];
      end
      if ((host_wr || host_rd) && ainc_r) ptr_r <= ptr_r + 1'b1;
      if (host_wr && (ptr_r == 7'h7F)) act_r <= 4'd1 + {1'b0, in_r.bus_value[6:4]};
      // channel register window
      if (wr_chan) begin
        case (wr_off)
          3'd0: freq_r[wr_ch][7:0]   <= in_r.bus_value;
          3'd2: freq_r[wr_ch][15:8]  <= in_r.bus_value;
          3'd4: begin
            freq_r[wr_ch][17:16] <= in_r.bus_value[1:0];
            if (len_r[wr_ch] != new_len) begin
              len_r[wr_ch] <= new_len;
              pos_r[wr_ch] <= '0;
            end
          end
          3'd6: base_r[wr_ch] <= in_r.bus_value;
          3'd7: vol_r[wr_ch]  <= in_r.bus_value[3:0];
          default: ;
        endcase
      end
      // tick sequencing
      if (cmd.ch_init) begin
        ch_r  <= st_c3[CW-1:0];
        acc_r <= '0;
      end
      if (cmd.ch_next) ch_r <= ch_r + 1'b1;
      if (cmd.div_start) div_cnt_r <= DIV_ITER;
      else if (cmd.div_step && div_cnt_r != 5'd0) div_cnt_r <= div_cnt_r - 1'b1;
      if (cmd.keep_phase) phase_r[ch_r] <= psum_r[23:0];
      if (cmd.save_steps) phase_r[ch_r] <= rem_r[23:0] + 24'd1;
      if (cmd.wrap_fetch) pos_r[ch_r] <= pos_new;
      if (cmd.nib_upd) nib_r[ch_r] <= nib_hi_r ? ram_q_r[7:4] : ram_q_r[3:0];
      if (cmd.accumulate) acc_r <= acc_r + prod;
    end
  end

endmodule

// ----- design/wavetable_sound_generator_8ch_top.sv -----
// Host transactions (address, data write, data read): after acceptance the sequencer passes
// through S_EXEC and S_DONE; the result loads once the output is free. Sample tick: per channel,
// up to three 25-step divisions on one shared serial divider, plus phase, wrap, RAM fetch and
// accumulate; a silent channel is skipped. One transaction at a time.
// Reset: synchronous active-low rst_n, then a pass clearing all 128 RAM bytes with in_ready low.
module wavetable_sound_generator_8ch_top
  import wsg_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  wsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wsg_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ----- test/wavetable_sound_generator_8ch_top_tb.sv -----
`timescale 1ns / 1ps

module wavetable_sound_generator_8ch_top_tb;
  import wsg_pkg::*;

  localparam int NCH = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  wavetable_sound_generator_8ch_top #(.NUM_CHANNELS(NCH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Shadow of the sound chip state
  logic [7:0] ram_q [RAM_BYTES];
  logic [6:0] ptr_q;
  logic auto_inc_q;
  logic [3:0] n_active_q;
  logic [17:0] freq_q [NCH];
  logic [5:0] len_q [NCH];
  logic [7:0] base_q [NCH];
  logic [3:0] vol_q [NCH];
  logic [3:0] nib_q [NCH];
  logic [4:0] pos_q [NCH];
  logic [23:0] phase_q [NCH];

  out_t expected_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  task automatic chip_reset();
    for (int i = 0; i < RAM_BYTES; i++) ram_q[i] = '0;
    ptr_q = '0;
    auto_inc_q = 1'b1;
    n_active_q = 4'd8;
    for (int c = 0; c < NCH; c++) begin
      freq_q[c] = '0; len_q[c] = 6'd16; base_q[c] = '0; vol_q[c] = '0;
      nib_q[c] = '0; pos_q[c] = '0; phase_q[c] = '0;
    end
  endtask

  // Advance one voice by the elapsed cycles; returns its signed contribution
  function automatic int voice_tick(int c, int cyc);
    longint period, ph, n, ln;
    int a;
    logic [7:0] b;
    if (freq_q[c] == 0) return 0;
    period = (longint'(32'hF0000) * n_active_q) / freq_q[c];
    if (period == 0) period = 1;
    ph = phase_q[c] + cyc;
    if (ph > period) begin
      n = (ph - 1) / period;
      ph -= n * period;
      ln = (len_q[c] == 0) ? 1 : len_q[c];
      pos_q[c] = 5'((pos_q[c] + (n % ln)) % ln);
      a = (base_q[c] + pos_q[c]) & 8'hFF;
      b = ram_q[(a >> 1) & (RAM_BYTES - 1)];
      nib_q[c] = (a & 1) ? b[7:4] : b[3:0];
    end
    phase_q[c] = ph[23:0];
    return (int'(nib_q[c]) - 8) * int'(vol_q[c]);
  endfunction

  // Predicted result of one host transaction
  function automatic out_t chip_step(in_t t);
    out_t r;
    int acc, st, c;
    logic [6:0] a;
    logic [7:0] v;
    r = '0;
    acc = 0;
    v = t.bus_value;
    case (t.mode)
      MODE_ADDR: begin
        ptr_q = v[6:0];
        auto_inc_q = v[7];
      end
      MODE_WR: begin
        a = ptr_q;
        ram_q[a] = v;
        if (a[6] && int'(a[5:3]) >= 8 - NCH) begin
          c = int'(a[5:3]) - (8 - NCH);
          case (a[2:0])
            3'd0: freq_q[c][7:0] = v;
            3'd2: freq_q[c][15:8] = v;
            3'd4: begin
              freq_q[c][17:16] = v[1:0];
              if (len_q[c] != 6'(32 - (v & 8'h1C))) begin
                len_q[c] = 6'(32 - (v & 8'h1C));
                pos_q[c] = '0;
              end
            end
            3'd6: base_q[c] = v;
            3'd7: vol_q[c] = v[3:0];
            default: ;
          endcase
        end
        if (a == 7'h7F) n_active_q = 4'(1 + ((v >> 4) & 7));
        if (auto_inc_q) ptr_q = ptr_q + 7'd1;
      end
      MODE_RD: begin
        r.read_data = ram_q[ptr_q];
        if (auto_inc_q) ptr_q = ptr_q + 7'd1;
      end
      default: begin
        st = (n_active_q >= 8) ? 0 : 8 - n_active_q;
        if (st < 8 - NCH) st = 8 - NCH;
        for (int w = st; w < 8; w++) acc += voice_tick(w - (8 - NCH), t.tick_cycles);
        r.sample = 16'(acc * 32);
      end
    endcase
    return r;
  endfunction

  // Directed stimulus; check flag marks rows with a hand-typed result
  typedef struct {
    in_t item;
    bit check;
    out_t want;
  } row_t;

  row_t dir_rows[] = '{
    '{'{MODE_TICK, 8'h00, 5'd16}, 1'b1, '{8'h00, 16'sh0000}},
    '{'{MODE_RD, 8'h00, 5'd0}, 1'b1, '{8'h00, 16'sh0000}},
    '{'{MODE_ADDR, 8'hFF, 5'd31}, 1'b1, '{8'h00, 16'sh0000}},
    '{'{MODE_WR, 8'h70, 5'd0}, 1'b1, '{8'h00, 16'sh0000}},
    '{'{MODE_ADDR, 8'hC0, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'hFF, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'h00, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'hFF, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'h00, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'h03, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'h00, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'hF0, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'h0F, 5'd0}, 1'b0, '0},
    '{'{MODE_ADDR, 8'h00, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'h5A, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'hA5, 5'd0}, 1'b0, '0},
    '{'{MODE_TICK, 8'h00, 5'd0}, 1'b0, '0},
    '{'{MODE_TICK, 8'h00, 5'd31}, 1'b0, '0},
    '{'{MODE_TICK, 8'hFF, 5'd16}, 1'b0, '0},
    '{'{MODE_ADDR, 8'h40, 5'd0}, 1'b0, '0},
    '{'{MODE_RD, 8'h00, 5'd0}, 1'b0, '0},
    '{'{MODE_RD, 8'h00, 5'd0}, 1'b0, '0},
    '{'{MODE_ADDR, 8'h7F, 5'd0}, 1'b0, '0},
    '{'{MODE_WR, 8'h00, 5'd0}, 1'b0, '0},
    '{'{MODE_TICK, 8'h00, 5'd1}, 1'b0, '0}
  };

  function automatic in_t rand_item();
    in_t t;
    int r;
    r = $urandom_range(0, 99);
    t.bus_value = 8'($urandom);
    t.tick_cycles = 5'($urandom);
    if (r < 12) begin
      t.mode = MODE_ADDR;
      // mostly aim at the channel windows, keeping auto-increment random
      if ($urandom_range(0, 2) != 0) t.bus_value[6] = 1'b1;
    end else if (r < 45) t.mode = MODE_WR;
    else if (r < 55) t.mode = MODE_RD;
    else t.mode = MODE_TICK;
    return t;
  endfunction

  // Offer one transaction and keep it until accepted
  task automatic send(in_t t);
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(chip_step(t));
  endtask

  // Stimulus: reset, directed table, then random bursts with gaps
  initial begin
    int burst;
    chip_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      send(dir_rows[i].item);
      if (dir_rows[i].check && expected_q[$] !== dir_rows[i].want) begin
        $display("%0t directed row %0d: expected %h got %h", $time, i,
                 dir_rows[i].want, expected_q[$]);
        errors++;
      end
    end
    hold_off = 1'b1;
    for (int n = 0; n < 700; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) send(rand_item());
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stalls; one long hold-off while the sender keeps offering
  initial begin
    int mode_sel;
    wait (rst_n);
    out_ready <= 1'b1;
    wait (hold_off);
    out_ready <= 1'b0;
    repeat (3000) @(posedge clk);
    forever begin
      mode_sel = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        if (mode_sel == 0) out_ready <= 1'b1;
        else if (mode_sel == 1) out_ready <= ($urandom_range(0, 1) == 1);
        else out_ready <= ($urandom_range(0, 5) == 0);
        @(posedge clk);
      end
    end
  end

  // Result checking at each accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none got %h", $time, out_data);
        errors++;
      end else begin
        if (out_data.read_data !== expected_q[0].read_data) begin
          $display("%0t read_data: expected %h got %h", $time,
                   expected_q[0].read_data, out_data.read_data);
          errors++;
        end
        if (out_data.sample !== expected_q[0].sample) begin
          $display("%0t sample: expected %0d got %0d", $time,
                   expected_q[0].sample, out_data.sample);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (expected_q.size() == 0);
    repeat (1000) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("PASS wavetable_sound_generator_8ch_top");
    else $display("FAIL wavetable_sound_generator_8ch_top");
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("FAIL wavetable_sound_generator_8ch_top");
    $finish;
  end

endmodule

// ----- sim.f -----
design/wsg_pkg.sv
design/wsg_ctrl.sv
design/wsg_dp.sv
design/wavetable_sound_generator_8ch_top.sv
test/wavetable_sound_generator_8ch_top_tb.sv
